>>> rtl/core/lbet_pkg.sv
// lbet_pkg: shared constants, opcodes and types for the eviction table
// depends on nothing; the interfaces and the top take it by scoped names
`default_nettype none

package lbet_pkg;

    localparam int ENTRIES     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int K_W         = $clog2(MAX_RESULTS + 1);
    localparam int ID_W        = 32;
    localparam int LEN_W       = 25;
    localparam int STAMP_W     = 32;
    localparam int TOT_W       = 32;
    localparam int WORD_W      = STAMP_W + LEN_W + ID_W;
    localparam logic [31:0] BUDGET_RESET = 32'd16777216;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_INSERT  = 3'd1,
        OP_TOUCH   = 3'd2,
        OP_SET_EV  = 3'd3,
        OP_SET_PER = 3'd4,
        OP_MATER   = 3'd5,
        OP_EVICT   = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             evicted;
        logic [ID_W-1:0]  victim_id;
        logic [LEN_W-1:0] victim_bytes;
        logic [TOT_W-1:0] freed_total;
        logic [TOT_W-1:0] resident_evictable_total;
        logic [TOT_W-1:0] footprint_total;
        logic             over_budget;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/lbet_item_if.sv
// lbet_item_if, lbet_result_if, lbet_cfg_if: valid/ready channels of the block
// depends on lbet_pkg for field widths
`default_nettype none

interface lbet_item_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  opcode;
    logic [lbet_pkg::ID_W-1:0]   entry_id;
    logic [lbet_pkg::LEN_W-1:0]  length;
    logic                        flag;
    logic [31:0]                 limit;
    modport source (output valid, opcode, entry_id, length, flag, limit, input ready);
    modport sink   (input valid, opcode, entry_id, length, flag, limit, output ready);
endinterface

interface lbet_result_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic                        evicted;
    logic [lbet_pkg::ID_W-1:0]   victim_id;
    logic [lbet_pkg::LEN_W-1:0]  victim_bytes;
    logic [31:0]                 freed_total;
    logic [31:0]                 resident_evictable_total;
    logic [31:0]                 footprint_total;
    logic                        over_budget;
    logic                        last;
    modport source (output valid, status, evicted, victim_id, victim_bytes, freed_total,
                    resident_evictable_total, footprint_total, over_budget, last,
                    input ready);
    modport sink   (input valid, status, evicted, victim_id, victim_bytes, freed_total,
                    resident_evictable_total, footprint_total, over_budget, last,
                    output ready);
endinterface

interface lbet_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lbet_ram.sv
// lbet_ram: simple dual-port synchronous ram, one write and one registered read
// depends on nothing
`default_nettype none

module lbet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lru_budget_eviction_table_top.sv
// lru_budget_eviction_table_top: entry table with lru eviction to a byte limit
// depends on lbet_pkg, the lbet interfaces and lbet_ram
//
//   channel  dir  beat
//   item     in   opcode, entry_id, length, flag, limit
//   result   out  status, evicted, victim, totals, over_budget, last
//   cfg      in   budget_bytes write data
//
// clear, insert and opcode seven skip the scan; lookups and evict-to-fit scan
// the filled entries of the ram at one entry a cycle.
// evict-to-fit repeats the scan for each victim, so it costs up to 16 scans.
// the result register stalls the sequencer while the sink holds ready low.
// reset clears flags, count, clock and totals at once; no clearing pass.
`default_nettype none

module lru_budget_eviction_table_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lbet_item_if.sink   item,
    lbet_result_if.source result,
    lbet_cfg_if.sink    cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FLUSH
    } state_t;

    localparam int IW = lbet_pkg::IDX_W;
    localparam int CW = lbet_pkg::CNT_W;
    localparam int KW = lbet_pkg::K_W;
    localparam int LW = lbet_pkg::LEN_W;
    localparam int SW = lbet_pkg::STAMP_W;
    localparam int DW = lbet_pkg::ID_W;
    localparam int WW = lbet_pkg::WORD_W;
    localparam int NE = lbet_pkg::ENTRIES;

    // opcode codes as plain vectors for the set test
    localparam logic [2:0] OP_TOUCH_C   = lbet_pkg::OP_TOUCH;
    localparam logic [2:0] OP_SET_EV_C  = lbet_pkg::OP_SET_EV;
    localparam logic [2:0] OP_SET_PER_C = lbet_pkg::OP_SET_PER;
    localparam logic [2:0] OP_MATER_C   = lbet_pkg::OP_MATER;
    localparam logic [2:0] OP_EVICT_C   = lbet_pkg::OP_EVICT;

    state_t state_reg, state_next;

    // latched operation
    lbet_pkg::op_t   op_reg;
    logic [DW-1:0]   id_reg;
    logic [LW-1:0]   len_reg;
    logic            flag_reg;
    logic [31:0]     limit_reg;

    // table state
    logic [NE-1:0]   res_reg, res_next;
    logic [NE-1:0]   per_reg, per_next;
    logic [NE-1:0]   ev_reg, ev_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [SW-1:0]   clock_reg, clock_next;
    logic [31:0]     re_tot_reg, re_tot_next;
    logic [31:0]     fp_tot_reg, fp_tot_next;
    logic [31:0]     budget_reg;

    // scan control
    logic [CW-1:0]   issue_reg, issue_next;
    logic            rv_reg, rv_next;
    logic [IW-1:0]   ridx_reg, ridx_next;
    logic            hit_reg, hit_next;
    logic [IW-1:0]   hidx_reg, hidx_next;
    logic [DW-1:0]   hid_reg, hid_next;
    logic [LW-1:0]   hlen_reg, hlen_next;
    logic [SW-1:0]   hstamp_reg, hstamp_next;

    // eviction progress
    logic [KW-1:0]   k_reg, k_next;
    logic [31:0]     freed_reg, freed_next;
    lbet_pkg::result_t pend_reg, pend_next;

    // result register
    logic              ov_reg, ov_next;
    lbet_pkg::result_t out_reg, out_next;

    // ram ports
    logic            we;
    logic [IW-1:0]   waddr;
    logic [WW-1:0]   wdata;
    logic            ren;
    logic [IW-1:0]   raddr;
    logic [WW-1:0]   rdata;

    logic            out_free;
    logic            accept;
    logic [DW-1:0]   rd_id;
    logic [LW-1:0]   rd_len;
    logic [SW-1:0]   rd_stamp;
    logic            rd_cand;
    logic [31:0]     hlen32;
    logic            old_c, old_f, new_c, new_f;
    logic            nr, np, ne;

    lbet_ram #(.WIDTH(WW), .DEPTH(NE), .AW(IW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ren),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign accept       = item.valid && item.ready;
    assign item.ready   = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign out_free     = !ov_reg || result.ready;
    assign {rd_stamp, rd_len, rd_id} = rdata;
    assign rd_cand      = res_reg[ridx_reg] && !per_reg[ridx_reg] && ev_reg[ridx_reg];
    assign hlen32       = 32'(hlen_reg);

    // result port
    assign result.valid                    = ov_reg;
    assign result.status                   = out_reg.status;
    assign result.evicted                  = out_reg.evicted;
    assign result.victim_id                = out_reg.victim_id;
    assign result.victim_bytes             = out_reg.victim_bytes;
    assign result.freed_total              = out_reg.freed_total;
    assign result.resident_evictable_total = out_reg.resident_evictable_total;
    assign result.footprint_total          = out_reg.footprint_total;
    assign result.over_budget              = out_reg.over_budget;
    assign result.last                     = out_reg.last;

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        res_next    = res_reg;
        per_next    = per_reg;
        ev_next     = ev_reg;
        count_next  = count_reg;
        clock_next  = clock_reg;
        re_tot_next = re_tot_reg;
        fp_tot_next = fp_tot_reg;
        issue_next  = issue_reg;
        rv_next     = 1'b0;
        ridx_next   = ridx_reg;
        hit_next    = hit_reg;
        hidx_next   = hidx_reg;
        hid_next    = hid_reg;
        hlen_next   = hlen_reg;
        hstamp_next = hstamp_reg;
        k_next      = k_reg;
        freed_next  = freed_reg;
        pend_next   = pend_reg;
        ov_next     = ov_reg && !result.ready;
        out_next    = out_reg;
        we          = 1'b0;
        waddr       = hidx_reg;
        wdata       = {hstamp_reg, hlen_reg, hid_reg};
        ren         = 1'b0;
        raddr       = issue_reg[IW-1:0];
        old_c       = res_reg[hidx_reg] && !per_reg[hidx_reg] && ev_reg[hidx_reg];
        old_f       = per_reg[hidx_reg] || !ev_reg[hidx_reg];
        nr          = res_reg[hidx_reg];
        np          = per_reg[hidx_reg];
        ne          = ev_reg[hidx_reg];
        new_c       = 1'b0;
        new_f       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    k_next     = '0;
                    freed_next = '0;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    if (item.opcode inside {OP_TOUCH_C, OP_SET_EV_C, OP_SET_PER_C,
                                            OP_MATER_C, OP_EVICT_C})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle over the filled entries
                if (issue_reg < count_reg)
                begin
                    ren        = 1'b1;
                    rv_next    = 1'b1;
                    ridx_next  = issue_reg[IW-1:0];
                    issue_next = issue_reg + CW'(1);
                end
                // look at the entry read last cycle
                if (rv_reg)
                begin
                    if (op_reg == lbet_pkg::OP_EVICT)
                    begin
                        if (rd_cand && (!hit_reg || rd_stamp < hstamp_reg))
                        begin
                            hit_next    = 1'b1;
                            hidx_next   = ridx_reg;
                            hid_next    = rd_id;
                            hlen_next   = rd_len;
                            hstamp_next = rd_stamp;
                        end
                    end
                    else if (!hit_reg && rd_id == id_reg)
                    begin
                        hit_next    = 1'b1;
                        hidx_next   = ridx_reg;
                        hid_next    = rd_id;
                        hlen_next   = rd_len;
                        hstamp_next = rd_stamp;
                    end
                end
                if (!rv_reg && !(issue_reg < count_reg))
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_next = '0;
                    out_next.last = 1'b1;
                    case (op_reg)
                        lbet_pkg::OP_CLEAR:
                        begin
                            res_next    = '0;
                            per_next    = '0;
                            ev_next     = '0;
                            count_next  = '0;
                            re_tot_next = '0;
                            fp_tot_next = '0;
                            ov_next     = 1'b1;
                            state_next  = S_IDLE;
                        end
                        lbet_pkg::OP_INSERT:
                        begin
                            if (count_reg >= CW'(NE))
                            begin
                                out_next.status = lbet_pkg::ST_FULL;
                            end
                            else
                            begin
                                we        = 1'b1;
                                waddr     = count_reg[IW-1:0];
                                wdata     = {SW'(0), len_reg, id_reg};
                                res_next[count_reg[IW-1:0]] = flag_reg;
                                per_next[count_reg[IW-1:0]] = 1'b0;
                                ev_next[count_reg[IW-1:0]]  = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (flag_reg)
                                begin
                                    re_tot_next = re_tot_reg + 32'(len_reg);
                                end
                            end
                            ov_next    = 1'b1;
                            state_next = S_IDLE;
                        end
                        lbet_pkg::OP_TOUCH, lbet_pkg::OP_SET_EV,
                        lbet_pkg::OP_SET_PER, lbet_pkg::OP_MATER:
                        begin
                            if (!hit_reg)
                            begin
                                out_next.status = lbet_pkg::ST_NOTFOUND;
                            end
                            else if (op_reg == lbet_pkg::OP_TOUCH)
                            begin
                                clock_next = clock_reg + SW'(1);
                                we         = 1'b1;
                                wdata      = {clock_reg + SW'(1), hlen_reg, hid_reg};
                            end
                            else
                            begin
                                if (op_reg == lbet_pkg::OP_SET_EV)
                                begin
                                    ne = flag_reg;
                                end
                                else if (op_reg == lbet_pkg::OP_SET_PER)
                                begin
                                    np = flag_reg;
                                end
                                else
                                begin
                                    nr = 1'b1;
                                end
                                new_c = nr && !np && ne;
                                new_f = np || !ne;
                                res_next[hidx_reg] = nr;
                                per_next[hidx_reg] = np;
                                ev_next[hidx_reg]  = ne;
                                re_tot_next = re_tot_reg - (old_c ? hlen32 : 32'd0)
                                              + (new_c ? hlen32 : 32'd0);
                                fp_tot_next = fp_tot_reg - (old_f ? hlen32 : 32'd0)
                                              + (new_f ? hlen32 : 32'd0);
                            end
                            ov_next    = 1'b1;
                            state_next = S_IDLE;
                        end
                        lbet_pkg::OP_EVICT:
                        begin
                            if (k_reg == '0 && (re_tot_reg <= limit_reg || !hit_reg))
                            begin
                                // nothing to drop
                                ov_next    = 1'b1;
                                state_next = S_IDLE;
                            end
                            else if (!hit_reg)
                            begin
                                // no candidate left: held victim closes the run
                                out_next   = pend_reg;
                                ov_next    = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                if (k_reg != '0)
                                begin
                                    out_next      = pend_reg;
                                    out_next.last = 1'b0;
                                    ov_next       = 1'b1;
                                end
                                res_next[hidx_reg] = 1'b0;
                                re_tot_next = re_tot_reg - hlen32;
                                freed_next  = freed_reg + hlen32;
                                k_next      = k_reg + KW'(1);
                                pend_next.status       = lbet_pkg::ST_OK;
                                pend_next.evicted      = 1'b1;
                                pend_next.victim_id    = hid_reg;
                                pend_next.victim_bytes = hlen_reg;
                                pend_next.freed_total  = freed_reg + hlen32;
                                pend_next.resident_evictable_total = re_tot_reg - hlen32;
                                pend_next.footprint_total = fp_tot_reg;
                                pend_next.over_budget  = fp_tot_reg > budget_reg;
                                pend_next.last         = 1'b1;
                                if (k_reg + KW'(1) >= KW'(lbet_pkg::MAX_RESULTS)
                                    || re_tot_reg - hlen32 <= limit_reg)
                                begin
                                    state_next = S_FLUSH;
                                end
                                else
                                begin
                                    issue_next = '0;
                                    hit_next   = 1'b0;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            ov_next    = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                    // totals shown on a non-victim beat follow this step
                    if (!out_next.evicted)
                    begin
                        out_next.resident_evictable_total = re_tot_next;
                        out_next.footprint_total          = fp_tot_next;
                        out_next.over_budget              = fp_tot_next > budget_reg;
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_next   = pend_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control, state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            res_reg    <= '0;
            per_reg    <= '0;
            ev_reg     <= '0;
            count_reg  <= '0;
            clock_reg  <= '0;
            re_tot_reg <= '0;
            fp_tot_reg <= '0;
            budget_reg <= lbet_pkg::BUDGET_RESET;
            issue_reg  <= '0;
            rv_reg     <= 1'b0;
            hit_reg    <= 1'b0;
            k_reg      <= '0;
            freed_reg  <= '0;
            ov_reg     <= 1'b0;
            out_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            res_reg    <= res_next;
            per_reg    <= per_next;
            ev_reg     <= ev_next;
            count_reg  <= count_next;
            clock_reg  <= clock_next;
            re_tot_reg <= re_tot_next;
            fp_tot_reg <= fp_tot_next;
            if (cfg.valid)
            begin
                budget_reg <= cfg.data;
            end
            issue_reg  <= issue_next;
            rv_reg     <= rv_next;
            hit_reg    <= hit_next;
            k_reg      <= k_next;
            freed_reg  <= freed_next;
            ov_reg     <= ov_next;
            out_reg    <= out_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= lbet_pkg::op_t'(item.opcode);
            id_reg    <= item.entry_id;
            len_reg   <= item.length;
            flag_reg  <= item.flag;
            limit_reg <= item.limit;
        end
        ridx_reg   <= ridx_next;
        hidx_reg   <= hidx_next;
        hid_reg    <= hid_next;
        hlen_reg   <= hlen_next;
        hstamp_reg <= hstamp_next;
        pend_reg   <= pend_next;
    end

endmodule

`default_nettype wire
